// File: sv/gfc_pkg.sv
// Shared sizes, cell codes, types and helpers for the grid frontier classifier.
// No dependencies; gfc_classify and the core refer to it by scoped names.
package gfc_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int MAX_CELLS = 65536;

  localparam int CELL_W = 8;                        // stored occupancy value
  localparam int CFG_W  = 9;                        // width of a config register
  localparam int ADDR_W = $clog2(MAX_CELLS);        // store address
  localparam int CNT_W  = $clog2(MAX_CELLS + 1);    // load count, holds MAX_CELLS
  localparam int POS_W  = $clog2(MAX_SIDE);         // row / column index
  localparam int EFF_W  = $clog2(MAX_SIDE + 1);     // clamped side length

  localparam logic [CELL_W-1:0] VAL_FREE       = CELL_W'(0);
  localparam logic [CELL_W-1:0] VAL_UNEXPLORED = CELL_W'(50);
  localparam logic [CELL_W-1:0] VAL_OUTSIDE    = CELL_W'(90);
  localparam logic [CELL_W-1:0] VAL_OCCUPIED   = CELL_W'(100);

  // neighbour slots
  localparam int NB_RIGHT = 0;
  localparam int NB_LEFT  = 1;
  localparam int NB_UP    = 2;
  localparam int NB_DOWN  = 3;
  localparam int NB_NUM   = 4;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic unexplored;
    logic occupied;
    logic frontier;
  } class_t;

  // Clamp a side register to 1..MAX_SIDE. With MAX_SIDE squared equal to
  // MAX_CELLS the area never exceeds the store, so no height cut is needed.
  function automatic logic [EFF_W-1:0] clamp_side(logic [CFG_W-1:0] v);
    logic [EFF_W-1:0] r;
    if (v == '0) begin
      r = EFF_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      r = EFF_W'(MAX_SIDE);
    end else begin
      r = EFF_W'(v);
    end
    return r;
  endfunction

endpackage

// File: sv/gfc_cell_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Standalone; no package dependency.
module gfc_cell_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: sv/gfc_classify.sv
// Cell classifier: unexplored / occupied / frontier flags from a cell and its
// four neighbours. Depends on gfc_pkg.
module gfc_classify (
  input  logic [gfc_pkg::NB_NUM-1:0][gfc_pkg::CELL_W-1:0] nb_i,
  input  logic [gfc_pkg::NB_NUM-1:0]                      nb_valid_i,
  input  logic [gfc_pkg::CELL_W-1:0]                      center_i,
  input  logic                                            pass_i,
  output gfc_pkg::class_t                                 class_o
);

  logic [gfc_pkg::CELL_W-1:0] target;
  logic [gfc_pkg::NB_NUM-1:0] hit;

  assign target = pass_i ? gfc_pkg::VAL_OUTSIDE : gfc_pkg::VAL_UNEXPLORED;

  // a neighbour off the grid reads as the outside code: only pass 1 matches it
  always_comb begin
    for (int k = 0; k < gfc_pkg::NB_NUM; k++) begin
      hit[k] = nb_valid_i[k] ? (nb_i[k] == target) : pass_i;
    end
  end

  always_comb begin
    class_o.frontier   = (center_i == gfc_pkg::VAL_FREE) && (|hit);
    class_o.unexplored = !pass_i && (center_i == gfc_pkg::VAL_UNEXPLORED);
    class_o.occupied   = !pass_i && (center_i == gfc_pkg::VAL_OCCUPIED);
  end

endmodule

// File: sv/grid_frontier_classifier_core.sv
// Grid frontier classifier top level: sequencer, scan counters, output register.
// Depends on gfc_pkg, gfc_cell_ram and gfc_classify.
//
// A load transfer (tuser 0) writes the next cell of the grid in raster order;
// loads beyond the grid size or during a scan are dropped. An advance transfer
// (tuser 1) yields one cell result: the cell and its four neighbours are five
// reads over the two read ports of the cell store, each with registered read
// data. No new transfer is taken until the result is registered, and an advance
// stalls while the previous result still waits on m_axis_tready. An advance before
// the grid is full is dropped. Pass 0 flags unexplored, occupied and frontier
// cells; if it finds no frontier, pass 1 rescans for free cells next to the grid
// border or a stored 90. The final result carries tlast and the block goes back
// to loading. A config write clamps each side to 1..256 and restarts loading.
// The store has no reset and needs no clearing pass: a scan only uses cells
// that were loaded.
module grid_frontier_classifier_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [gfc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [7:0]                s_axis_tdata_i,  // [7:0] cell_value
  input  logic [0:0]                s_axis_tuser_i,  // [0] opcode
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // [7:0] cell_row, [15:8] cell_col, [16] scan_pass, [17] is_unexplored,
  // [18] is_occupied, [19] is_frontier, [23:20] zero
  output logic [23:0]               m_axis_tdata_o,
  output logic                      m_axis_tlast_o
);

  localparam int ADDR_W = gfc_pkg::ADDR_W;
  localparam int CNT_W  = gfc_pkg::CNT_W;
  localparam int POS_W  = gfc_pkg::POS_W;
  localparam int EFF_W  = gfc_pkg::EFF_W;
  localparam int CELL_W = gfc_pkg::CELL_W;

  gfc_pkg::state_e state_q, state_d;

  logic [EFF_W-1:0]   eff_w_q, eff_h_q;
  logic [2*EFF_W-1:0] area;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   load_cnt_q;
  logic [ADDR_W-1:0]  idx_q;
  logic [POS_W-1:0]   row_q, col_q;
  logic               pass_q, seen_q, scanning_q;

  logic               s_fire, grid_full, load_we, start, eval_fire;
  logic               col_last, row_last, cell_last, to_pass1;
  logic [ADDR_W-1:0]  raddr_a, raddr_b;
  logic [CELL_W-1:0]  rdata_a, rdata_b;
  logic [CELL_W-1:0]  center_q, right_q, left_q, up_q;
  logic [gfc_pkg::NB_NUM-1:0][CELL_W-1:0] nb;
  logic [gfc_pkg::NB_NUM-1:0]             nb_valid;
  gfc_pkg::class_t    cls;

  logic               out_valid_q;
  logic [POS_W-1:0]   out_row_q, out_col_q;
  logic               out_pass_q, out_last_q;
  gfc_pkg::class_t    out_cls_q;

  assign area      = eff_w_q * eff_h_q;
  assign total     = area[CNT_W-1:0];
  assign grid_full = (load_cnt_q == total);
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;

  assign col_last  = (EFF_W'(col_q) + EFF_W'(1)) == eff_w_q;
  assign row_last  = (EFF_W'(row_q) + EFF_W'(1)) == eff_h_q;
  assign cell_last = col_last && row_last;
  assign to_pass1  = !pass_q && !(seen_q || cls.frontier);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    load_we         = 1'b0;
    start           = 1'b0;
    eval_fire       = 1'b0;
    raddr_a         = idx_q;
    raddr_b         = idx_q + ADDR_W'(1);
    unique case (state_q)
      gfc_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_fire) begin
          if (s_axis_tuser_i == gfc_pkg::OP_LOAD) begin
            load_we = !scanning_q && !grid_full;
          end else if (scanning_q || grid_full) begin
            start   = !scanning_q;
            state_d = gfc_pkg::ST_RD1;
          end
        end
      end
      gfc_pkg::ST_RD1: begin
        raddr_a = idx_q - ADDR_W'(1);
        raddr_b = idx_q - ADDR_W'(eff_w_q);
        state_d = gfc_pkg::ST_RD2;
      end
      gfc_pkg::ST_RD2: begin
        raddr_a = idx_q + ADDR_W'(eff_w_q);
        state_d = gfc_pkg::ST_EVAL;
      end
      gfc_pkg::ST_EVAL: begin
        // keep the lower neighbour on port a while the output is blocked
        raddr_a = idx_q + ADDR_W'(eff_w_q);
        if (!out_valid_q || m_axis_tready_i) begin
          eval_fire = 1'b1;
          state_d   = gfc_pkg::ST_IDLE;
        end
      end
      default: state_d = gfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- store
  gfc_cell_ram #(
    .DATA_W (CELL_W),
    .ADDR_W (ADDR_W)
  ) u_cell_ram (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .waddr_i   (load_cnt_q[ADDR_W-1:0]),
    .wdata_i   (s_axis_tdata_i[CELL_W-1:0]),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // read data lands in the cycle after its address
  always_ff @(posedge clk_i) begin
    if (state_q == gfc_pkg::ST_RD1) begin
      center_q <= rdata_a;
      right_q  <= rdata_b;
    end
    if (state_q == gfc_pkg::ST_RD2) begin
      left_q <= rdata_a;
      up_q   <= rdata_b;
    end
  end

  always_comb begin
    nb[gfc_pkg::NB_RIGHT]       = right_q;
    nb[gfc_pkg::NB_LEFT]        = left_q;
    nb[gfc_pkg::NB_UP]          = up_q;
    nb[gfc_pkg::NB_DOWN]        = rdata_a;
    nb_valid[gfc_pkg::NB_RIGHT] = !col_last;
    nb_valid[gfc_pkg::NB_LEFT]  = (col_q != '0);
    nb_valid[gfc_pkg::NB_UP]    = (row_q != '0);
    nb_valid[gfc_pkg::NB_DOWN]  = !row_last;
  end

  gfc_classify u_classify (
    .nb_i       (nb),
    .nb_valid_i (nb_valid),
    .center_i   (center_q),
    .pass_i     (pass_q),
    .class_o    (cls)
  );

  // ---------------------------------------------------------------- scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q    <= EFF_W'(gfc_pkg::MAX_SIDE);
      eff_h_q    <= EFF_W'(gfc_pkg::MAX_SIDE);
      load_cnt_q <= '0;
      idx_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      pass_q     <= 1'b0;
      seen_q     <= 1'b0;
      scanning_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gfc_pkg::REG_GRID_WIDTH:  eff_w_q <= gfc_pkg::clamp_side(cfg_wdata_i);
        gfc_pkg::REG_GRID_HEIGHT: eff_h_q <= gfc_pkg::clamp_side(cfg_wdata_i);
        default: ;
      endcase
      load_cnt_q <= '0;
      idx_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      pass_q     <= 1'b0;
      seen_q     <= 1'b0;
      scanning_q <= 1'b0;
    end else begin
      if (load_we) begin
        load_cnt_q <= load_cnt_q + CNT_W'(1);
      end
      if (start) begin
        scanning_q <= 1'b1;
      end
      if (eval_fire) begin
        if (!pass_q && cls.frontier) begin
          seen_q <= 1'b1;
        end
        if (!cell_last) begin
          idx_q <= idx_q + ADDR_W'(1);
          if (col_last) begin
            col_q <= '0;
            row_q <= row_q + POS_W'(1);
          end else begin
            col_q <= col_q + POS_W'(1);
          end
        end else begin
          idx_q <= '0;
          row_q <= '0;
          col_q <= '0;
          if (to_pass1) begin
            pass_q <= 1'b1;
          end else begin
            pass_q     <= 1'b0;
            seen_q     <= 1'b0;
            scanning_q <= 1'b0;
            load_cnt_q <= '0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_fire) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_pass_q <= pass_q;
      out_cls_q  <= cls;
      out_last_q <= cell_last && !to_pass1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {4'b0, out_cls_q.frontier, out_cls_q.occupied,
                            out_cls_q.unexplored, out_pass_q,
                            8'(out_col_q), 8'(out_row_q)};

  // ---------------------------------------------------------------- assertions
  a_busy_only_scanning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != gfc_pkg::ST_IDLE) |-> scanning_q)
    else $error("sequencer busy outside a scan");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |-> (load_cnt_q <= total))
    else $error("load count beyond grid size");

  a_last_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval_fire && cell_last && !to_pass1 && !cfg_we_i) |=>
      (!scanning_q && load_cnt_q == '0 && !pass_q))
    else $error("final result did not return to loading");

  a_pass1_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_pass_q) |-> !(out_cls_q.unexplored || out_cls_q.occupied))
    else $error("class flags set in fallback pass");

  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scanning_q |-> (EFF_W'(col_q) < eff_w_q && EFF_W'(row_q) < eff_h_q))
    else $error("scan position outside grid");

endmodule
